// ===== rtl/pbe_pkg.sv =====
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared types and constants for the postfix boolean evaluator.
// ----------------------------------------------------------------------------
package pbe_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 1024;
  localparam int unsigned VAR_W           = 26;
  localparam int unsigned APB_AW          = 2;
  localparam int unsigned APB_DW          = 32;

  // token characters
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_ONE  = 8'h31;  // '1'
  localparam logic [7:0] CHAR_NOT  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_AND  = 8'h26;  // '&'
  localparam logic [7:0] CHAR_OR   = 8'h7C;  // '|'
  localparam logic [7:0] CHAR_EQ   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_IMP  = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_XOR  = 8'h23;  // '#'
  localparam logic [7:0] CHAR_LO_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LO_Z = 8'h7A;  // 'z'

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_INVALID   = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_e;

  typedef struct packed {
    logic value_bit;
    logic is_operator_result;
    logic is_final;
    err_e error_code;
  } res_t;

endpackage

// ===== rtl/pbe_stream_if.sv =====
// ----------------------------------------------------------------------------
// pbe_stream_if
// Valid/ready channels for formula tokens and evaluation results.
// ----------------------------------------------------------------------------
interface pbe_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_char;
  logic       start_formula;
  logic       last_token;

  modport source (output valid, token_char, start_formula, last_token, input ready);
  modport sink   (input valid, token_char, start_formula, last_token, output ready);
endinterface

interface pbe_res_if;
  logic       valid;
  logic       ready;
  logic       value_bit;
  logic       is_operator_result;
  logic       is_final;
  logic [1:0] error_code;

  modport source (output valid, value_bit, is_operator_result, is_final, error_code,
                  input ready);
  modport sink   (input valid, value_bit, is_operator_result, is_final, error_code,
                  output ready);
endinterface

// ===== rtl/pbe_eval.sv =====
// ----------------------------------------------------------------------------
// pbe_eval
// Token decode and operand stack. The top two entries live in registers,
// deeper entries in a one-port-write, one-port-read synchronous memory.
// ----------------------------------------------------------------------------
module pbe_eval
  import pbe_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       token_char_i,
  input  logic             start_formula_i,
  input  logic             last_token_i,
  input  logic [VAR_W-1:0] vars_i,
  output res_t             res_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic          mem [STACK_DEPTH];
  logic [CW-1:0] count_q, count_d;
  logic          inv_q, inv_d;
  logic          top_q, top_d;
  logic          next_q, next_d;
  logic          rd_bit_q;
  logic          byp_q, byp_d;
  logic          byp_bit_q;

  logic [CW-1:0] cnt;
  logic          inv_prev;
  logic          is_const, is_letter, is_operand, is_not, is_bin, bad_char, inv_now;
  logic          pv, third, have1, have2, full;
  logic          a_bit, b_bit, a_one, b_one, eq_val, op_val;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] raddr_full, waddr_full;

  // effective state after an optional start
  assign cnt      = start_formula_i ? '0 : count_q;
  assign inv_prev = start_formula_i ? 1'b0 : inv_q;

  assign is_const   = (token_char_i == CHAR_ZERO) || (token_char_i == CHAR_ONE);
  assign is_letter  = (token_char_i >= CHAR_LO_A) && (token_char_i <= CHAR_LO_Z);
  assign is_operand = is_const || is_letter;
  assign is_not     = (token_char_i == CHAR_NOT);
  assign is_bin     = (token_char_i == CHAR_AND) || (token_char_i == CHAR_OR) ||
                      (token_char_i == CHAR_EQ)  || (token_char_i == CHAR_IMP) ||
                      (token_char_i == CHAR_XOR);
  assign bad_char   = !(is_operand || is_not || is_bin);
  assign inv_now    = inv_prev || bad_char;

  // 'a' has low five bits 1, so subtract one for the variable index
  assign pv = is_const ? token_char_i[0] : vars_i[token_char_i[4:0] - 5'd1];

  assign third = byp_q ? byp_bit_q : rd_bit_q;
  assign have1 = (cnt != '0);
  assign have2 = (cnt > CW'(1));
  assign full  = (cnt == CW'(STACK_DEPTH));

  // a is popped first (top), b second; an empty operand is neither 0 nor 1
  assign a_bit  = top_q;
  assign b_bit  = next_q;
  assign a_one  = have1 && a_bit;
  assign b_one  = have2 && b_bit;
  assign eq_val = (!have1 && !have2) || (have1 && have2 && (a_bit == b_bit));

  always_comb begin
    unique case (token_char_i)
      CHAR_AND: op_val = a_one && b_one;
      CHAR_OR:  op_val = a_one || b_one;
      CHAR_EQ:  op_val = eq_val;
      CHAR_IMP: op_val = (have2 && !b_bit) || a_one;
      CHAR_XOR: op_val = !eq_val;
      default:  op_val = have1 && !a_bit;
    endcase
  end

  assign waddr_full = cnt - CW'(2);
  assign waddr      = waddr_full[AW-1:0];
  assign we         = accept_i && !inv_now && is_operand && !full && have2;

  always_comb begin
    count_d = count_q;
    inv_d   = inv_q;
    top_d   = top_q;
    next_d  = next_q;
    if (accept_i) begin
      count_d = cnt;
      inv_d   = inv_now;
      if (!inv_now) begin
        if (is_operand) begin
          if (!full) begin
            next_d  = top_q;
            top_d   = pv;
            count_d = cnt + CW'(1);
          end
        end else if (is_not) begin
          top_d   = op_val;
          count_d = have1 ? cnt : CW'(1);
        end else begin
          top_d   = op_val;
          next_d  = third;
          count_d = have2 ? cnt - CW'(1) : CW'(1);
        end
      end
    end
  end

  // keep the third entry prefetched for the coming count
  assign raddr_full = count_d - CW'(3);
  assign raddr      = raddr_full[AW-1:0];
  assign byp_d      = we && (waddr == raddr);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= next_q;
    end
    rd_bit_q  <= mem[raddr];
    byp_bit_q <= next_q;
    top_q     <= top_d;
    next_q    <= next_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      inv_q   <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      inv_q   <= inv_d;
      byp_q   <= byp_d;
    end
  end

  always_comb begin
    res_o.is_final = last_token_i;
    if (inv_now) begin
      res_o.value_bit          = 1'b0;
      res_o.is_operator_result = 1'b0;
      res_o.error_code         = ERR_INVALID;
    end else if (is_operand) begin
      res_o.value_bit          = last_token_i && pv;
      res_o.is_operator_result = 1'b0;
      res_o.error_code         = full ? ERR_OVERFLOW : ERR_OK;
    end else begin
      res_o.value_bit          = op_val;
      res_o.is_operator_result = 1'b1;
      res_o.error_code         = (is_not ? !have1 : !have2) ? ERR_UNDERFLOW : ERR_OK;
    end
  end

endmodule

// ===== rtl/postfix_boolean_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// postfix_boolean_evaluator_top
// Evaluates a postfix boolean formula streamed one character per transfer.
// Latency: result is valid the cycle after the token transfer.
// Throughput: one token per cycle unless the result output stalls; stack
//   top is in registers and memory prefetches the third entry each cycle.
// Reset clears stack count, invalid flag and the variable register; stack
//   memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module postfix_boolean_evaluator_top
  import pbe_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  pbe_tok_if.sink           token_i,
  pbe_res_if.source         result_o
);

  logic [VAR_W-1:0] vars_q;
  logic             cfg_wr;
  logic             accept;
  logic             out_valid_q, out_valid_d;
  res_t             res;
  res_t             out_q;

  // the variable register is the only word, so every address selects it
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = APB_DW'(vars_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vars_q <= '0;
    end else if (cfg_wr) begin
      vars_q <= pwdata[VAR_W-1:0];
    end
  end

  // take a new token whenever the result register is empty or draining
  assign token_i.ready = !out_valid_q || result_o.ready;
  assign accept        = token_i.valid && token_i.ready;

  pbe_eval #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_eval (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .token_char_i   (token_i.token_char),
    .start_formula_i(token_i.start_formula),
    .last_token_i   (token_i.last_token),
    .vars_i         (vars_q),
    .res_o          (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.value_bit          = out_q.value_bit;
  assign result_o.is_operator_result = out_q.is_operator_result;
  assign result_o.is_final           = out_q.is_final;
  assign result_o.error_code         = out_q.error_code;

endmodule
